// ===== hdl/rabin_encrypt_decrypt_engine_macros.svh =====
// Assertion macros shared by the Rabin engine RTL.
`ifndef RABIN_ENCRYPT_DECRYPT_ENGINE_MACROS_SVH
`define RABIN_ENCRYPT_DECRYPT_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define REDE_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rede assertion failed");
// Expression must never be true outside reset.
`define REDE_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("rede forbidden condition");
`else
`define REDE_ASSERT(label, prop)
`define REDE_NEVER(label, expr)
`endif

`endif

// ===== hdl/rede_pkg.sv =====
`timescale 1ns / 1ps
package rede_pkg;
	localparam int MOD_BITS  = 64;
	localparam int HALF_BITS = MOD_BITS / 2;
	localparam int COEF_W    = HALF_BITS + 2;
	localparam int CNT_W     = $clog2(MOD_BITS);
	localparam int HCNT_W    = $clog2(HALF_BITS);
	localparam int ADDR_W    = 5;

	localparam logic [MOD_BITS-1:0] CHECK_MASK = MOD_BITS'(32'h0000_AAAA);

	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	localparam logic [1:0] REG_MODULUS = 2'd0;
	localparam logic [1:0] REG_PRIME_P = 2'd1;
	localparam logic [1:0] REG_PRIME_Q = 2'd2;

	typedef struct packed {
		logic                start;
		logic [MOD_BITS-1:0] a;
		logic [MOD_BITS-1:0] b;
		logic [MOD_BITS-1:0] m;
	} mm_req_t;

	typedef struct packed {
		logic                 start;
		logic [HALF_BITS-1:0] dividend;
		logic [HALF_BITS-1:0] divisor;
	} div_req_t;
endpackage

// ===== hdl/rede_mulmod.sv =====
`timescale 1ns / 1ps
// a*b mod m, one bit of b per cycle, MSB first. Requires a < m; m <= 1 gives 0.
module rede_mulmod import rede_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  mm_req_t             req,
	output logic                done,
	output logic [MOD_BITS-1:0] result
);
	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] a_q;
	logic [MOD_BITS-1:0] b_q;
	logic [MOD_BITS-1:0] m_q;
	logic [MOD_BITS:0]   dbl, dbl_r, sum, sum_r;
	logic [MOD_BITS-1:0] acc_next;

	always_comb begin
		dbl      = {acc_q, 1'b0};
		dbl_r    = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		sum      = dbl_r + {1'b0, a_q};
		sum_r    = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
		acc_next = b_q[MOD_BITS-1] ? sum_r[MOD_BITS-1:0] : dbl_r[MOD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (req.m[MOD_BITS-1:1] == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
				cnt_q <= CNT_W'(MOD_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q   <= req.a;
			b_q   <= req.b;
			m_q   <= req.m;
		end else if (busy_q) begin
			acc_q <= acc_next;
			b_q   <= {b_q[MOD_BITS-2:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = acc_q;
endmodule

// ===== hdl/rede_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module rede_div import rede_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  div_req_t             req,
	output logic                 done,
	output logic [HALF_BITS-1:0] quotient,
	output logic [HALF_BITS-1:0] remainder
);
	logic                 busy_q;
	logic                 done_q;
	logic [HCNT_W-1:0]    cnt_q;
	logic [HALF_BITS-1:0] quo_q;
	logic [HALF_BITS-1:0] rem_q;
	logic [HALF_BITS-1:0] dsr_q;
	logic [HALF_BITS:0]   trial;
	logic                 fits;

	always_comb begin
		trial = {rem_q, quo_q[HALF_BITS-1]};
		fits  = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= HCNT_W'(HALF_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? HALF_BITS'(trial - {1'b0, dsr_q}) : trial[HALF_BITS-1:0];
			quo_q <= {quo_q[HALF_BITS-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

// ===== hdl/rabin_encrypt_decrypt_engine.sv =====
`timescale 1ns / 1ps
// Encrypt: four passes through the 64-step mod-multiply unit.
// Decrypt: four modular exponentiations with 31-bit exponents
// share the same mod-multiply unit, plus an extended Euclid on a 32-step divider.
// One request at a time: in_ready is low from accept until the result is taken.
// Reset clears all config registers to zero and returns the sequencer to idle.
`include "rabin_encrypt_decrypt_engine_macros.svh"
module rabin_encrypt_decrypt_engine import rede_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [MOD_BITS-1:0] data_word,
	input  logic [MOD_BITS-1:0] check_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [MOD_BITS-1:0] out_word,
	output logic [MOD_BITS-1:0] check_out,
	output logic                found
);
	typedef enum logic [4:0] {
		S_IDLE, S_ENC_RED, S_ENC_SQ, S_DIV, S_MULK, S_UPD, S_COEF, S_CA, S_CB,
		S_PBASE, S_PLOOP, S_PMUL, S_PSQ, S_U, S_V, S_X01, S_X23, S_CMP, S_OUT
	} state_t;

	state_t state_q;

	logic [MOD_BITS-1:0]  modulus_n_q;
	logic [HALF_BITS-1:0] prime_p_q, prime_q_q;
	logic                 cfg_wr;

	logic [MOD_BITS-1:0]  data_q, chk_q, mod_n_q, t_q, u_q;
	logic [MOD_BITS-1:0]  ap_q, bq_q, cs_q, ct_q, base_q, racc_q, rr_q, ss_q;
	logic [MOD_BITS-1:0]  x0_q, x1_q;
	logic [MOD_BITS-1:0]  xm_q [4];
	logic [MOD_BITS-1:0]  xc_q [4];
	logic [HALF_BITS-2:0] e_q;
	logic                 enc_sel_q, word_sel_q, prime_sel_q, issued_q;
	logic [1:0]           ci_q, cj_q;
	logic [HALF_BITS-1:0] r0_q, r1_q, k_q, rem_q;
	logic signed [COEF_W-1:0] s0_q, s1_q, t0_q, t1_q, ks_q, kt_q;
	logic [MOD_BITS-1:0]  out_word_q, check_out_q;
	logic                 found_q;

	mm_req_t              mm_req;
	logic                 mm_done;
	logic [MOD_BITS-1:0]  mm_res;
	logic                 mm_use;
	div_req_t             div_req;
	logic                 div_done;
	logic [HALF_BITS-1:0] div_quo, div_rem;

	logic [HALF_BITS-1:0]       pm;
	logic [MOD_BITS-1:0]        pm_ext, mask, w_word, pq, x0_n, x1_n;
	logic [HALF_BITS:0]         e_full;
	logic [MOD_BITS:0]          sum_uv;
	logic signed [COEF_W+HALF_BITS:0] ks_full, kt_full;
	logic [MOD_BITS-1:0]        sx, tx, su, tu;

	// Config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_n_q <= '0;
			prime_p_q   <= '0;
			prime_q_q   <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				REG_MODULUS: modulus_n_q <= pwdata[MOD_BITS-1:0];
				REG_PRIME_P: prime_p_q   <= pwdata[HALF_BITS-1:0];
				REG_PRIME_Q: prime_q_q   <= pwdata[HALF_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_MODULUS: prdata = 64'(modulus_n_q);
			REG_PRIME_P: prdata = 64'(prime_p_q);
			REG_PRIME_Q: prdata = 64'(prime_q_q);
			default:     prdata = '0;
		endcase
	end

	// Datapath helpers
	always_comb begin
		pm      = prime_sel_q ? prime_q_q : prime_p_q;
		pm_ext  = MOD_BITS'(pm);
		e_full  = {1'b0, pm} + (HALF_BITS+1)'(1);
		mask    = mod_n_q & CHECK_MASK;
		w_word  = data_q | mask;
		pq      = MOD_BITS'(prime_p_q) * MOD_BITS'(prime_q_q);
		ks_full = $signed({1'b0, k_q}) * s1_q;
		kt_full = $signed({1'b0, k_q}) * t1_q;
		// Bezout coefficient to [0, n): negative values wrap through n
		sx      = {{(MOD_BITS-COEF_W){s0_q[COEF_W-1]}}, s0_q};
		tx      = {{(MOD_BITS-COEF_W){t0_q[COEF_W-1]}}, t0_q};
		su      = s0_q[COEF_W-1] ? mod_n_q + sx : sx;
		tu      = t0_q[COEF_W-1] ? mod_n_q + tx : tx;
		sum_uv  = {1'b0, u_q} + {1'b0, t_q};
		x0_n    = (sum_uv >= {1'b0, mod_n_q}) ? MOD_BITS'(sum_uv - {1'b0, mod_n_q})
		                                      : sum_uv[MOD_BITS-1:0];
		x1_n    = (u_q >= t_q) ? u_q - t_q : u_q + (mod_n_q - t_q);
	end

	// Operand select for the shared multiply unit
	always_comb begin
		mm_use   = 1'b1;
		mm_req.a = '0;
		mm_req.b = '0;
		mm_req.m = mod_n_q;
		unique case (state_q)
			S_ENC_RED: begin
				mm_req.a = MOD_BITS'(1);
				mm_req.b = enc_sel_q ? w_word : data_q;
			end
			S_ENC_SQ: begin
				mm_req.a = t_q;
				mm_req.b = t_q;
			end
			S_CA: begin
				mm_req.a = cs_q;
				mm_req.b = MOD_BITS'(prime_p_q);
			end
			S_CB: begin
				mm_req.a = ct_q;
				mm_req.b = MOD_BITS'(prime_q_q);
			end
			S_PBASE: begin
				mm_req.a = MOD_BITS'(1);
				mm_req.b = word_sel_q ? chk_q : data_q;
				mm_req.m = pm_ext;
			end
			S_PMUL: begin
				mm_req.a = racc_q;
				mm_req.b = base_q;
				mm_req.m = pm_ext;
			end
			S_PSQ: begin
				mm_req.a = base_q;
				mm_req.b = base_q;
				mm_req.m = pm_ext;
			end
			S_U: begin
				mm_req.a = ap_q;
				mm_req.b = ss_q;
			end
			S_V: begin
				mm_req.a = bq_q;
				mm_req.b = rr_q;
			end
			default: mm_use = 1'b0;
		endcase
		mm_req.start     = mm_use && !issued_q;
		div_req.start    = (state_q == S_DIV) && !issued_q && (r1_q != '0);
		div_req.dividend = r0_q;
		div_req.divisor  = r1_q;
	end

	rede_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.done   (mm_done),
		.result (mm_res)
	);

	rede_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issued_q    <= 1'b0;
			enc_sel_q   <= 1'b0;
			word_sel_q  <= 1'b0;
			prime_sel_q <= 1'b0;
			ci_q        <= '0;
			cj_q        <= '0;
		end else begin
			if (mm_req.start || div_req.start) begin
				issued_q <= 1'b1;
			end
			if (mm_done || div_done) begin
				issued_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						data_q      <= data_word;
						chk_q       <= check_in;
						out_word_q  <= '0;
						check_out_q <= '0;
						found_q     <= 1'b0;
						enc_sel_q   <= 1'b0;
						if (cmd == CMD_DECRYPT) begin
							mod_n_q <= pq;
							r0_q    <= prime_p_q;
							r1_q    <= prime_q_q;
							s0_q    <= COEF_W'(1);
							s1_q    <= '0;
							t0_q    <= '0;
							t1_q    <= COEF_W'(1);
							if (prime_p_q == '0 || prime_q_q == '0) begin
								state_q <= S_OUT;
							end else begin
								state_q <= S_DIV;
							end
						end else begin
							mod_n_q <= modulus_n_q;
							state_q <= S_ENC_RED;
						end
					end
				end
				S_ENC_RED: begin
					if (mm_done) begin
						t_q     <= mm_res;
						state_q <= S_ENC_SQ;
					end
				end
				S_ENC_SQ: begin
					if (mm_done) begin
						if (!enc_sel_q) begin
							out_word_q <= mm_res;
							enc_sel_q  <= 1'b1;
							state_q    <= S_ENC_RED;
						end else begin
							check_out_q <= mm_res;
							found_q     <= 1'b1;
							state_q     <= S_OUT;
						end
					end
				end
				S_DIV: begin
					if (r1_q == '0) begin
						state_q <= S_COEF;
					end else if (div_done) begin
						k_q     <= div_quo;
						rem_q   <= div_rem;
						state_q <= S_MULK;
					end
				end
				S_MULK: begin
					ks_q    <= ks_full[COEF_W-1:0];
					kt_q    <= kt_full[COEF_W-1:0];
					state_q <= S_UPD;
				end
				S_UPD: begin
					r0_q    <= r1_q;
					r1_q    <= rem_q;
					s0_q    <= s1_q;
					s1_q    <= s0_q - ks_q;
					t0_q    <= t1_q;
					t1_q    <= t0_q - kt_q;
					state_q <= S_DIV;
				end
				S_COEF: begin
					cs_q    <= (su >= mod_n_q) ? su - mod_n_q : su;
					ct_q    <= (tu >= mod_n_q) ? tu - mod_n_q : tu;
					state_q <= S_CA;
				end
				S_CA: begin
					if (mm_done) begin
						ap_q    <= mm_res;
						state_q <= S_CB;
					end
				end
				S_CB: begin
					if (mm_done) begin
						bq_q        <= mm_res;
						word_sel_q  <= 1'b0;
						prime_sel_q <= 1'b0;
						state_q     <= S_PBASE;
					end
				end
				S_PBASE: begin
					if (mm_done) begin
						base_q  <= mm_res;
						racc_q  <= (pm[HALF_BITS-1:1] == '0) ? '0 : MOD_BITS'(1);
						e_q     <= e_full[HALF_BITS:2];
						state_q <= S_PLOOP;
					end
				end
				S_PLOOP: begin
					if (e_q == '0) begin
						if (!prime_sel_q) begin
							rr_q        <= racc_q;
							prime_sel_q <= 1'b1;
							state_q     <= S_PBASE;
						end else begin
							ss_q        <= racc_q;
							prime_sel_q <= 1'b0;
							state_q     <= S_U;
						end
					end else if (e_q[0]) begin
						state_q <= S_PMUL;
					end else begin
						state_q <= S_PSQ;
					end
				end
				S_PMUL: begin
					if (mm_done) begin
						racc_q  <= mm_res;
						state_q <= S_PSQ;
					end
				end
				S_PSQ: begin
					if (mm_done) begin
						base_q  <= mm_res;
						e_q     <= e_q >> 1;
						state_q <= S_PLOOP;
					end
				end
				S_U: begin
					if (mm_done) begin
						u_q     <= mm_res;
						state_q <= S_V;
					end
				end
				S_V: begin
					if (mm_done) begin
						t_q     <= mm_res;
						state_q <= S_X01;
					end
				end
				S_X01: begin
					x0_q    <= x0_n;
					x1_q    <= x1_n;
					state_q <= S_X23;
				end
				S_X23: begin
					if (!word_sel_q) begin
						xm_q[0] <= x0_q;
						xm_q[1] <= x1_q;
						xm_q[2] <= (x0_q == '0) ? '0 : mod_n_q - x0_q;
						xm_q[3] <= (x1_q == '0) ? '0 : mod_n_q - x1_q;
						word_sel_q <= 1'b1;
						state_q    <= S_PBASE;
					end else begin
						xc_q[0] <= x0_q;
						xc_q[1] <= x1_q;
						xc_q[2] <= (x0_q == '0) ? '0 : mod_n_q - x0_q;
						xc_q[3] <= (x1_q == '0) ? '0 : mod_n_q - x1_q;
						ci_q    <= '0;
						cj_q    <= '0;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					// xm rotates past xc[0]; after four steps advance to the next check root
					if (xc_q[0] == (xm_q[0] | mask)) begin
						out_word_q <= xm_q[0];
						found_q    <= 1'b1;
						state_q    <= S_OUT;
					end else begin
						xm_q[0] <= xm_q[1];
						xm_q[1] <= xm_q[2];
						xm_q[2] <= xm_q[3];
						xm_q[3] <= xm_q[0];
						cj_q    <= cj_q + 1'b1;
						if (cj_q == 2'd3) begin
							xc_q[0] <= xc_q[1];
							xc_q[1] <= xc_q[2];
							xc_q[2] <= xc_q[3];
							ci_q    <= ci_q + 1'b1;
							if (ci_q == 2'd3) begin
								state_q <= S_OUT;
							end
						end
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_word  = out_word_q;
	assign check_out = check_out_q;
	assign found     = found_q;

	`REDE_NEVER(a_ready_and_valid, in_ready && out_valid)
	`REDE_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready)
	`REDE_ASSERT(a_miss_gives_zero, out_valid && !found |-> out_word == '0)
	`REDE_NEVER(a_two_units_at_once, mm_req.start && div_req.start)
endmodule
